@@ rtl/core/bti_pkg.sv @@
`timescale 1ns / 1ps
package bti_pkg;

    localparam logic [1:0] ACT_LOAD      = 2'd0;
    localparam logic [1:0] ACT_INTERP    = 2'd1;
    localparam logic [1:0] ACT_INTEGRATE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam logic [1:0] CFG_CE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_KE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_CE_ENABLE = 2'd2;
    localparam logic [1:0] CFG_CONST_CE  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic               table_select;
        logic [5:0]         entry_index;
        logic [31:0]        temperature;
        logic signed [31:0] entry_value;
    } item_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } result_t;

    typedef enum logic [5:0] {
        OP_NOP, OP_LATCH, OP_RD_FIRST, OP_RD_LAST, OP_CAP_LAST,
        OP_SRCH_RD, OP_SRCH_UPD, OP_RD_LO, OP_RD_HI, OP_CAP_HI,
        OP_SEG_PREP, OP_SEG_FLAT, OP_SEG_CE, OP_DIV_INIT, OP_DIV_STEP,
        OP_MS_CONST, OP_MS_FIRST, OP_MS_LAST, OP_MS_OFFDY, OP_MS_TRAP,
        OP_MS_LD0, OP_MS_LDN, OP_MUL0, OP_MUL1, OP_MUL_FIN,
        OP_RES_EMPTY, OP_RES_FIRST, OP_RES_LAST, OP_RES_CE, OP_RES_MS,
        OP_RES_ADD, OP_LD_RD, OP_LD_CAP, OP_LD_WR, OP_LD_PWR0, OP_LD_PWRN
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RD_LAST, S_CAP_LAST, S_DECIDE, S_SRCH,
        S_SRCH_UPD, S_RD_HI, S_CAP_HI, S_SEG_PREP, S_SEG_BR, S_DIV_INIT,
        S_DIV, S_SEG_CE, S_SEG_USE, S_MUL0, S_MUL1, S_MUL_FIN, S_RES_MS,
        S_RES_ADD, S_LD_CAP, S_LD_WR, S_LD_MS, S_LD_P0, S_LD_PN, S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       load_ok;
        logic       idx_zero;
        logic       sel_zero;
        logic       n_zero;
        logic       ce_enable;
        logic       t_le_lo;
        logic       t_ge_hi;
        logic       srch_done;
        logic       dt_le0;
        logic       div_last;
    } dp_stat_t;

endpackage

@@ rtl/core/bti_ram.sv @@
`timescale 1ns / 1ps
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/bti_datapath.sv @@
`timescale 1ns / 1ps
module bti_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bti_pkg::item_t   item,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  bti_pkg::dp_cmd_t cmd,
    output bti_pkg::dp_stat_t stat,
    output bti_pkg::result_t result
);
    import bti_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int AW = $clog2(2 * TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [6:0]         ce_cnt_reg;
    logic [6:0]         ke_cnt_reg;
    logic               ena_reg;
    logic signed [31:0] const_reg;

    logic [1:0]         act_reg;
    logic               sel_reg;
    logic [IW-1:0]      idx_reg;
    logic               load_ok_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      n_reg;
    logic [31:0]        ta_reg;
    logic [31:0]        tb_reg;
    logic signed [31:0] ya_reg;
    logic signed [31:0] yb_reg;
    logic signed [63:0] pref_reg;
    logic [IW-1:0]      lo_reg;
    logic [IW-1:0]      hi_reg;
    logic [IW-1:0]      mid_reg;
    logic [31:0]        dt_reg;
    logic               dt_le0_reg;
    logic [31:0]        off_reg;
    logic               dy_neg_reg;
    logic [32:0]        dy_mag_reg;
    logic signed [33:0] ce_reg;
    logic [33:0]        ua_reg;
    logic [33:0]        ub_reg;
    logic               neg_reg;
    logic               sh9_reg;
    logic [67:0]        acc_reg;
    logic signed [63:0] ms_reg;
    logic [31:0]        div_r_reg;
    logic [32:0]        div_n_reg;
    logic [32:0]        div_q_reg;
    logic [5:0]         div_cnt_reg;
    logic signed [63:0] res_reg;
    logic [1:0]         status_reg;

    logic               tv_we;
    logic [AW-1:0]      tv_waddr;
    logic [AW-1:0]      tv_raddr;
    logic [31:0]        t_rd;
    logic [31:0]        v_rd;
    logic               p_we;
    logic [IW-1:0]      p_raddr;
    logic [63:0]        p_wdata;
    logic [63:0]        p_rd;

    logic [IW-1:0]      n_m1;
    logic [IW-1:0]      idx_m1;
    logic [IW-1:0]      mid_w;
    logic [6:0]         cnt_sel;
    logic [CW-1:0]      n_next;
    logic signed [33:0] ma;
    logic signed [33:0] mb;
    logic               msh9;
    logic [50:0]        pp;
    logic signed [67:0] sprod;
    logic signed [67:0] sshift;
    logic signed [32:0] dt_w;
    logic signed [32:0] off_w;
    logic signed [32:0] dy_w;
    logic [32:0]        div_rs;
    logic               div_ge;
    logic signed [33:0] ya34;
    logic signed [33:0] yb34;
    logic signed [33:0] val34;

    function automatic logic [AW-1:0] tv_addr(input logic s, input logic [IW-1:0] i);
        tv_addr = s ? AW'(TABLE_DEPTH) + AW'(i) : AW'(i);
    endfunction

    function automatic logic [33:0] abs34(input logic signed [33:0] x);
        abs34 = x[33] ? 34'(-x) : 34'(x);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            sat_add = s;
        end
    endfunction

    function automatic logic item_le(input logic [31:0] a, input logic [31:0] b);
        item_le = a <= b;
    endfunction

    bti_ram #(.WIDTH(32), .DEPTH(2 * TABLE_DEPTH)) u_temps (
        .clk(clk), .we(tv_we), .waddr(tv_waddr), .wdata(t_reg),
        .raddr(tv_raddr), .rdata(t_rd)
    );

    bti_ram #(.WIDTH(32), .DEPTH(2 * TABLE_DEPTH)) u_values (
        .clk(clk), .we(tv_we), .waddr(tv_waddr), .wdata(val_reg),
        .raddr(tv_raddr), .rdata(v_rd)
    );

    bti_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_prefix (
        .clk(clk), .we(p_we), .waddr(idx_reg), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rd)
    );

    assign n_m1   = IW'(n_reg - CW'(1));
    assign idx_m1 = idx_reg - IW'(1);
    assign mid_w  = IW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign ya34   = {{2{ya_reg[31]}}, ya_reg};
    assign yb34   = {{2{yb_reg[31]}}, yb_reg};
    assign val34  = {{2{val_reg[31]}}, val_reg};
    assign dt_w   = $signed({1'b0, tb_reg}) - $signed({1'b0, ta_reg});
    assign off_w  = $signed({1'b0, t_reg}) - $signed({1'b0, ta_reg});
    assign dy_w   = $signed({yb_reg[31], yb_reg}) - $signed({ya_reg[31], ya_reg});
    assign cnt_sel = (item.table_select && item.action != ACT_INTEGRATE)
                     ? ke_cnt_reg : ce_cnt_reg;
    assign n_next = (32'(cnt_sel) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_sel);
    assign pp     = ua_reg * ((cmd.op == OP_MUL1) ? ub_reg[33:17] : ub_reg[16:0]);
    assign sprod  = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    assign sshift = sh9_reg ? (sprod >>> 9) : (sprod >>> 8);
    assign div_rs = {div_r_reg, div_n_reg[32]};
    assign div_ge = div_rs >= {1'b0, dt_reg};

    always_comb
    begin
        tv_we    = (cmd.op == OP_LD_WR);
        tv_waddr = tv_addr(sel_reg, idx_reg);
        p_we     = (cmd.op == OP_LD_PWR0) || (cmd.op == OP_LD_PWRN);
        p_wdata  = (cmd.op == OP_LD_PWR0) ? ms_reg : sat_add(pref_reg, ms_reg);
        tv_raddr = tv_addr(sel_reg, lo_reg);
        p_raddr  = lo_reg;
        case (cmd.op)
            OP_RD_FIRST: tv_raddr = tv_addr(sel_reg, IW'(0));
            OP_RD_LAST:
            begin
                tv_raddr = tv_addr(sel_reg, n_m1);
                p_raddr  = n_m1;
            end
            OP_SRCH_RD:  tv_raddr = tv_addr(sel_reg, mid_w);
            OP_RD_HI:    tv_raddr = tv_addr(sel_reg, lo_reg + IW'(1));
            OP_LD_RD:
            begin
                tv_raddr = tv_addr(sel_reg, idx_m1);
                p_raddr  = idx_m1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ma   = val34;
        mb   = $signed({2'b00, t_reg});
        msh9 = 1'b0;
        case (cmd.op)
            OP_MS_CONST: ma = {{2{const_reg[31]}}, const_reg};
            OP_MS_FIRST: ma = ya34;
            OP_MS_LAST:
            begin
                ma = yb34;
                mb = $signed({2'b00, t_reg}) - $signed({2'b00, tb_reg});
            end
            OP_MS_OFFDY:
            begin
                ma = $signed({2'b00, off_reg});
                mb = $signed({1'b0, dy_mag_reg});
            end
            OP_MS_TRAP:
            begin
                ma   = ya34 + ce_reg;
                mb   = $signed({2'b00, off_reg});
                msh9 = 1'b1;
            end
            OP_MS_LDN:
            begin
                ma   = val34 + ya34;
                mb   = $signed({2'b00, t_reg}) - $signed({2'b00, ta_reg});
                msh9 = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ce_cnt_reg <= 7'd0;
            ke_cnt_reg <= 7'd0;
            ena_reg    <= 1'b0;
            const_reg  <= 32'sd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CE_COUNT:  ce_cnt_reg <= cfg_data[6:0];
                CFG_KE_COUNT:  ke_cnt_reg <= cfg_data[6:0];
                CFG_CE_ENABLE: ena_reg    <= cfg_data[0];
                CFG_CONST_CE:  const_reg  <= $signed(cfg_data);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                act_reg     <= item.action;
                sel_reg     <= (item.action == ACT_INTEGRATE) ? 1'b0 : item.table_select;
                idx_reg     <= IW'(item.entry_index);
                load_ok_reg <= 32'(item.entry_index) < 32'(TABLE_DEPTH);
                t_reg       <= item.temperature;
                val_reg     <= item.entry_value;
                n_reg       <= n_next;
                res_reg     <= 64'sd0;
                status_reg  <= ST_OK;
            end
            OP_RD_LAST:
            begin
                ta_reg <= t_rd;
                ya_reg <= $signed(v_rd);
            end
            OP_CAP_LAST:
            begin
                tb_reg   <= t_rd;
                yb_reg   <= $signed(v_rd);
                pref_reg <= $signed(p_rd);
                lo_reg   <= IW'(0);
                hi_reg   <= n_m1;
            end
            OP_SRCH_RD: mid_reg <= mid_w;
            OP_SRCH_UPD:
            begin
                if (t_reg < t_rd)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg;
                end
            end
            OP_RD_HI, OP_LD_CAP:
            begin
                ta_reg   <= t_rd;
                ya_reg   <= $signed(v_rd);
                pref_reg <= $signed(p_rd);
                if (cmd.op == OP_LD_CAP && item_le(t_reg, t_rd))
                begin
                    status_reg <= ST_ORDER;
                end
            end
            OP_CAP_HI:
            begin
                tb_reg <= t_rd;
                yb_reg <= $signed(v_rd);
            end
            OP_SEG_PREP:
            begin
                dt_reg     <= dt_w[31:0];
                dt_le0_reg <= (dt_w <= 33'sd0);
                if (off_w < 33'sd0)
                begin
                    off_reg <= 32'd0;
                end
                else if (dt_w > 33'sd0 && off_w > dt_w)
                begin
                    off_reg <= dt_w[31:0];
                end
                else
                begin
                    off_reg <= off_w[31:0];
                end
                dy_neg_reg <= dy_w[32];
                dy_mag_reg <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
            end
            OP_SEG_FLAT: ce_reg <= ya34;
            OP_SEG_CE:
            begin
                ce_reg <= dy_neg_reg ? ya34 - $signed({1'b0, div_q_reg})
                                     : ya34 + $signed({1'b0, div_q_reg});
            end
            OP_DIV_INIT:
            begin
                div_r_reg   <= acc_reg[64:33];
                div_n_reg   <= acc_reg[32:0];
                div_q_reg   <= 33'd0;
                div_cnt_reg <= 6'd33;
            end
            OP_DIV_STEP:
            begin
                div_r_reg   <= div_ge ? 32'(div_rs - {1'b0, dt_reg}) : div_rs[31:0];
                div_n_reg   <= {div_n_reg[31:0], 1'b0};
                div_q_reg   <= {div_q_reg[31:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            OP_MS_CONST, OP_MS_FIRST, OP_MS_LAST, OP_MS_OFFDY, OP_MS_TRAP,
            OP_MS_LD0, OP_MS_LDN:
            begin
                ua_reg  <= abs34(ma);
                ub_reg  <= abs34(mb);
                neg_reg <= ma[33] ^ mb[33];
                sh9_reg <= msh9;
            end
            OP_MUL0:    acc_reg <= 68'(pp);
            OP_MUL1:    acc_reg <= acc_reg + (68'(pp) << 17);
            OP_MUL_FIN: ms_reg  <= sshift[63:0];
            OP_RES_EMPTY: status_reg <= ST_EMPTY;
            OP_RES_FIRST: res_reg <= 64'(ya34);
            OP_RES_LAST:  res_reg <= 64'(yb34);
            OP_RES_CE:    res_reg <= 64'(ce_reg);
            OP_RES_MS:    res_reg <= ms_reg;
            OP_RES_ADD:   res_reg <= sat_add(pref_reg, ms_reg);
            default: ;
        endcase
    end

    always_comb
    begin
        stat.act       = act_reg;
        stat.load_ok   = load_ok_reg;
        stat.idx_zero  = (idx_reg == IW'(0));
        stat.sel_zero  = !sel_reg;
        stat.n_zero    = (n_reg == CW'(0));
        stat.ce_enable = ena_reg;
        stat.t_le_lo   = t_reg <= ta_reg;
        stat.t_ge_hi   = t_reg >= tb_reg;
        stat.srch_done = (hi_reg - lo_reg) <= IW'(1);
        stat.dt_le0    = dt_le0_reg;
        stat.div_last  = (div_cnt_reg == 6'd1);
    end

    assign result.result_value = res_reg;
    assign result.status       = status_reg;
endmodule

@@ rtl/core/bti_ctrl.sv @@
`timescale 1ns / 1ps
module bti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bti_pkg::dp_stat_t stat,
    output bti_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import bti_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t ret_reg;
    ctrl_state_t ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.act == ACT_LOAD)
                begin
                    if (!stat.load_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.idx_zero)
                    begin
                        state_next = S_LD_WR;
                    end
                    else
                    begin
                        cmd.op     = OP_LD_RD;
                        state_next = S_LD_CAP;
                    end
                end
                else if (stat.act == ACT_INTERP || stat.act == ACT_INTEGRATE)
                begin
                    cmd.op     = OP_RD_FIRST;
                    state_next = S_RD_LAST;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_LAST:
            begin
                cmd.op     = OP_RD_LAST;
                state_next = S_CAP_LAST;
            end
            S_CAP_LAST:
            begin
                cmd.op     = OP_CAP_LAST;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.act == ACT_INTERP)
                begin
                    state_next = S_DONE;
                    if (stat.n_zero)
                    begin
                        cmd.op = OP_RES_EMPTY;
                    end
                    else if (stat.t_le_lo)
                    begin
                        cmd.op = OP_RES_FIRST;
                    end
                    else if (stat.t_ge_hi)
                    begin
                        cmd.op = OP_RES_LAST;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
                else
                begin
                    state_next = S_MUL0;
                    if (!stat.ce_enable)
                    begin
                        cmd.op   = OP_MS_CONST;
                        ret_next = S_RES_MS;
                    end
                    else if (stat.n_zero)
                    begin
                        cmd.op     = OP_RES_EMPTY;
                        state_next = S_DONE;
                    end
                    else if (stat.t_le_lo)
                    begin
                        cmd.op   = OP_MS_FIRST;
                        ret_next = S_RES_MS;
                    end
                    else if (stat.t_ge_hi)
                    begin
                        cmd.op   = OP_MS_LAST;
                        ret_next = S_RES_ADD;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (stat.srch_done)
                begin
                    cmd.op     = OP_RD_LO;
                    state_next = S_RD_HI;
                end
                else
                begin
                    cmd.op     = OP_SRCH_RD;
                    state_next = S_SRCH_UPD;
                end
            end
            S_SRCH_UPD:
            begin
                cmd.op     = OP_SRCH_UPD;
                state_next = S_SRCH;
            end
            S_RD_HI:
            begin
                cmd.op     = OP_RD_HI;
                state_next = S_CAP_HI;
            end
            S_CAP_HI:
            begin
                cmd.op     = OP_CAP_HI;
                state_next = S_SEG_PREP;
            end
            S_SEG_PREP:
            begin
                cmd.op     = OP_SEG_PREP;
                state_next = S_SEG_BR;
            end
            S_SEG_BR:
            begin
                if (stat.dt_le0)
                begin
                    cmd.op     = OP_SEG_FLAT;
                    state_next = S_SEG_USE;
                end
                else
                begin
                    cmd.op     = OP_MS_OFFDY;
                    ret_next   = S_DIV_INIT;
                    state_next = S_MUL0;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_SEG_CE;
                end
            end
            S_SEG_CE:
            begin
                cmd.op     = OP_SEG_CE;
                state_next = S_SEG_USE;
            end
            S_SEG_USE:
            begin
                if (stat.act == ACT_INTERP)
                begin
                    cmd.op     = OP_RES_CE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_MS_TRAP;
                    ret_next   = S_RES_ADD;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.op     = OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL_FIN;
            end
            S_MUL_FIN:
            begin
                cmd.op     = OP_MUL_FIN;
                state_next = ret_reg;
            end
            S_RES_MS:
            begin
                cmd.op     = OP_RES_MS;
                state_next = S_DONE;
            end
            S_RES_ADD:
            begin
                cmd.op     = OP_RES_ADD;
                state_next = S_DONE;
            end
            S_LD_CAP:
            begin
                cmd.op     = OP_LD_CAP;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.op     = OP_LD_WR;
                state_next = stat.sel_zero ? S_LD_MS : S_DONE;
            end
            S_LD_MS:
            begin
                state_next = S_MUL0;
                if (stat.idx_zero)
                begin
                    cmd.op   = OP_MS_LD0;
                    ret_next = S_LD_P0;
                end
                else
                begin
                    cmd.op   = OP_MS_LDN;
                    ret_next = S_LD_PN;
                end
            end
            S_LD_P0:
            begin
                cmd.op     = OP_LD_PWR0;
                state_next = S_DONE;
            end
            S_LD_PN:
            begin
                cmd.op     = OP_LD_PWRN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_busy_ends_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result beat");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held more than one cycle");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted beat did not start work");

    a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_INIT |=> state_reg == S_DIV)
        else $error("divider not entered after init");
endmodule

@@ rtl/core/breakpoint_table_interpolator.sv @@
`timescale 1ns / 1ps
// Two breakpoint tables (specific heat, conductivity) with piecewise linear
// lookup and a trapezoid integral of table zero. An item is accepted when
// start is high and busy low; its result beat appears on result for exactly
// one cycle with done high, and must be taken then. One item at a time: a
// new item is not accepted until the result beat of the last one has been
// given. The time an item takes is set by the steps of the binary search
// through the tables, which have one read port each, the 33-step restoring
// divider for the segment slope, and the two-pass multiplier.
// Tables hold undefined data until loaded; no clearing pass is run.
module breakpoint_table_interpolator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bti_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output bti_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import bti_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bti_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .cmd(cmd), .busy(busy), .done(done)
    );

    bti_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd),
        .stat(stat), .result(result)
    );
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import bti_pkg::*;

    localparam int DEPTH = 64;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    logic        clk;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        done;
    result_t     result;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    breakpoint_table_interpolator #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the block's tables and registers
    logic [31:0] bp_temp [2*DEPTH];
    longint      bp_val  [2*DEPTH];
    longint      prefix  [DEPTH];
    logic [6:0]  ce_count;
    logic [6:0]  ke_count;
    logic        ce_enable;
    longint      const_ce;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors = 0;
    int      gap = 0;
    bit      no_idle = 0;

    // generator-side view of what has been loaded
    logic [31:0] gen_temp [2*DEPTH];
    int          loaded_len [2];
    int          item_count = 0;

    initial clk = 0;
    always #10 clk = ~clk;

    function automatic longint mul_floor(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> sh;
        if (p > S64_MAX) return S64_MAX;
        if (p < S64_MIN) return S64_MIN;
        return p[63:0];
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [127:0] s, pa, pb;
        pa = a;
        pb = b;
        s = pa + pb;
        if (s > S64_MAX) return S64_MAX;
        if (s < S64_MIN) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic longint temp_of(int idx);
        return longint'({32'd0, bp_temp[idx]});
    endfunction

    function automatic int find_segment(int base, int n, logic [31:0] t);
        int lo, hi, mid;
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (t < bp_temp[base + mid]) hi = mid;
            else lo = mid;
        end
        return lo;
    endfunction

    function automatic longint segment_value(int base, int lo, logic [31:0] t,
                                             output longint off);
        longint tl, dt, yl, dy, ady;
        logic [127:0] q;
        tl = temp_of(base + lo);
        dt = temp_of(base + lo + 1) - tl;
        yl = bp_val[base + lo];
        dy = bp_val[base + lo + 1] - yl;
        off = longint'({32'd0, t}) - tl;
        if (off < 0) off = 0;
        if (dt <= 0) return yl;
        if (off > dt) off = dt;
        ady = dy < 0 ? -dy : dy;
        q = (128'(off) * 128'(ady)) / 128'(dt);
        return dy < 0 ? yl - longint'(q[63:0]) : yl + longint'(q[63:0]);
    endfunction

    task automatic predict_beat(input item_t it);
        result_t r;
        int base, idx, n, lo;
        longint t, v, off, ce;
        r = '0;
        base = it.table_select ? DEPTH : 0;
        idx = it.entry_index;
        t = longint'({32'd0, it.temperature});
        v = it.entry_value;
        r.status = ST_OK;
        case (it.action)
            ACT_LOAD: begin
                bp_temp[base + idx] = it.temperature;
                bp_val[base + idx] = v;
                if (idx > 0 && it.temperature <= bp_temp[base + idx - 1])
                    r.status = ST_ORDER;
                if (!it.table_select) begin
                    if (idx == 0)
                        prefix[0] = mul_floor(v, t, 8);
                    else
                        prefix[idx] = add_sat(prefix[idx - 1],
                            mul_floor(v + bp_val[idx - 1], t - temp_of(idx - 1), 9));
                end
            end
            ACT_INTERP: begin
                n = it.table_select ? ke_count : ce_count;
                if (n > DEPTH) n = DEPTH;
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (it.temperature <= bp_temp[base])
                    r.result_value = bp_val[base];
                else if (it.temperature >= bp_temp[base + n - 1])
                    r.result_value = bp_val[base + n - 1];
                else
                    r.result_value = segment_value(base,
                        find_segment(base, n, it.temperature), it.temperature, off);
            end
            ACT_INTEGRATE: begin
                n = ce_count > DEPTH ? DEPTH : ce_count;
                if (!ce_enable)
                    r.result_value = mul_floor(const_ce, t, 8);
                else if (n == 0)
                    r.status = ST_EMPTY;
                else if (it.temperature <= bp_temp[0])
                    r.result_value = mul_floor(bp_val[0], t, 8);
                else if (it.temperature >= bp_temp[n - 1])
                    r.result_value = add_sat(prefix[n - 1],
                        mul_floor(bp_val[n - 1], t - temp_of(n - 1), 8));
                else begin
                    lo = find_segment(0, n, it.temperature);
                    ce = segment_value(0, lo, it.temperature, off);
                    r.result_value = add_sat(prefix[lo],
                        mul_floor(bp_val[lo] + ce, off, 9));
                end
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_start;
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            next_start = start;
            if (start && !busy)
            begin
                predict_beat(item);
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap > 0)
                    gap--;
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    next_start = 1'b1;
                    if (no_idle || $urandom_range(0, 9) < 6)
                        gap = 0;
                    else if ($urandom_range(0, 9) < 8)
                        gap = $urandom_range(1, 3);
                    else
                        gap = $urandom_range(10, 40);
                end
            end
            start <= next_start;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: value %0d status %0d",
                       result.result_value, result.status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.result_value !== want.result_value)
                begin
                    $error("result_value expected %0d actual %0d",
                           want.result_value, result.result_value);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, result.status);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] act, input logic sel, input int idx,
                             input logic [31:0] t, input logic [31:0] v);
        item_t it;
        it.action = act;
        it.table_select = sel;
        it.entry_index = idx[5:0];
        it.temperature = t;
        it.entry_value = v;
        if (act == ACT_LOAD)
        begin
            gen_temp[(sel ? DEPTH : 0) + idx] = t;
            if (idx == loaded_len[sel]) loaded_len[sel]++;
        end
        pending_items.insert(pending_items.size(), it);
        item_count++;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            CFG_CE_COUNT:  ce_count = d[6:0];
            CFG_KE_COUNT:  ke_count = d[6:0];
            CFG_CE_ENABLE: ce_enable = d[0];
            default:       const_ce = longint'(signed'(d));
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_table(input logic sel, input int len);
        longint t;
        int step_bits;
        step_bits = $urandom_range(0, 24);
        t = $urandom_range(0, 1000);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                if ($urandom_range(0, 14) == 0)
                    t = t - $urandom_range(0, 50);
                else
                    t = t + $urandom_range(1, 1 << step_bits);
                if (t < 0) t = 0;
                if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            end
            push_item(ACT_LOAD, sel, i, t[31:0], rand_value());
        end
    endtask

    function automatic int pick_count(input int len);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return len >= 1 ? 1 : 0;
            2: return (len == DEPTH) ? $urandom_range(DEPTH, 127) : len;
            default: return len == 0 ? 0 : $urandom_range(1, len);
        endcase
    endfunction

    function automatic logic [31:0] query_temp(input logic sel, input int n);
        int base;
        base = sel ? DEPTH : 0;
        if (n > DEPTH) n = DEPTH;
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default:
                if (n < 2 || gen_temp[base + n - 1] <= gen_temp[base])
                    return $urandom;
                else
                    return $urandom_range(gen_temp[base], gen_temp[base + n - 1]);
        endcase
    endfunction

    initial
    begin : stimulus
        int n_ce, n_ke, sel, idx;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_CE_COUNT;
        cfg_data = '0;
        ce_count = 0;
        ke_count = 0;
        ce_enable = 0;
        const_ce = 0;
        loaded_len[0] = 0;
        loaded_len[1] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tables, disabled table zero, unknown action
        push_item(ACT_INTERP, 0, 0, 32'h100, 0);
        push_item(ACT_INTERP, 1, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(ACT_INTEGRATE, 0, 0, 32'hFFFF_FFFF, 0);
        push_item(2'd3, 1, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // extremes, out-of-order load, degenerate segment
        push_item(ACT_LOAD, 0, 0, 32'h0, 32'h7FFF_FFFF);
        push_item(ACT_LOAD, 0, 1, 32'd100, 32'h8000_0000);
        push_item(ACT_LOAD, 0, 2, 32'd100, 32'd5);
        push_item(ACT_LOAD, 0, 3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_item(ACT_LOAD, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(ACT_LOAD, 1, 1, 32'h0, 32'h1);
        drain();
        write_reg(CFG_CE_COUNT, 4);
        write_reg(CFG_KE_COUNT, 2);
        write_reg(CFG_CE_ENABLE, 1);
        write_reg(CFG_CONST_CE, 32'h8000_0000);
        push_item(ACT_INTERP, 0, 0, 32'h0, 0);
        push_item(ACT_INTERP, 0, 0, 32'd50, 0);
        push_item(ACT_INTERP, 0, 0, 32'd100, 0);
        push_item(ACT_INTERP, 0, 0, 32'd200, 0);
        push_item(ACT_INTERP, 0, 0, 32'hFFFF_FFFF, 0);
        push_item(ACT_INTERP, 1, 0, 32'd5, 0);
        push_item(ACT_INTEGRATE, 0, 0, 32'h0, 0);
        push_item(ACT_INTEGRATE, 0, 0, 32'd50, 0);
        push_item(ACT_INTEGRATE, 0, 0, 32'd150, 0);
        push_item(ACT_INTEGRATE, 0, 0, 32'hFFFF_FFFF, 0);
        drain();
        write_reg(CFG_CE_ENABLE, 0);
        push_item(ACT_INTEGRATE, 1, 0, 32'hFFFF_FFFF, 0);
        drain();
        write_reg(CFG_CONST_CE, 32'h7FFF_FFFF);
        push_item(ACT_INTEGRATE, 0, 0, 32'hFFFF_FFFF, 0);
        drain();

        while (item_count < 760)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 1);
            load_table(sel, ($urandom_range(0, 5) == 0) ? DEPTH : $urandom_range(2, 12));
            if ($urandom_range(0, 2) == 0)
                load_table(!sel, $urandom_range(1, 8));
            drain();
            n_ce = pick_count(loaded_len[0]);
            n_ke = pick_count(loaded_len[1]);
            write_reg(CFG_CE_COUNT, n_ce);
            write_reg(CFG_KE_COUNT, n_ke);
            write_reg(CFG_CE_ENABLE, ($urandom_range(0, 3) != 0));
            write_reg(CFG_CONST_CE, rand_value());
            for (int i = 0; i < 40; i++)
            begin
                case ($urandom_range(0, 9))
                    0: begin
                        sel = $urandom_range(0, 1);
                        idx = $urandom_range(0, loaded_len[sel] > 63 ? 63 : loaded_len[sel]);
                        push_item(ACT_LOAD, sel, idx, $urandom, rand_value());
                    end
                    1: push_item(2'd3, $urandom_range(0, 1), $urandom_range(0, 63),
                                 $urandom, $urandom);
                    2, 3, 4, 5: begin
                        sel = $urandom_range(0, 1);
                        push_item(ACT_INTERP, sel, $urandom_range(0, 63),
                                  query_temp(sel, sel ? n_ke : n_ce), $urandom);
                    end
                    default: push_item(ACT_INTEGRATE, $urandom_range(0, 1),
                                       $urandom_range(0, 63), query_temp(0, n_ce),
                                       $urandom);
                endcase
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("breakpoint_table_interpolator test passed");
        else
            $display("breakpoint_table_interpolator test failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("breakpoint_table_interpolator test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/bti_pkg.sv
rtl/core/bti_ram.sv
rtl/core/bti_datapath.sv
rtl/core/bti_ctrl.sv
rtl/core/breakpoint_table_interpolator.sv
tb/testbench.sv
